/* rtl/core/rbmc_pkg.sv */
// Package for the RGBA blend-mode compositor.
// Holds the pipeline payload type, mode codes and the 8-bit rounding multiply.
// No dependencies.
package rbmc_pkg;

    localparam int NumStages = 14;
    localparam int DivFirst  = 3;
    localparam int DivBits   = 8;
    localparam int NumLanes  = 6;

    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_MULT      = 2'd1;
    localparam logic [1:0] MODE_MULT_CORR = 2'd2;
    localparam logic [1:0] MODE_MERGE     = 2'd3;

    localparam logic [1:0] CFG_BLEND_MODE    = 2'd0;
    localparam logic [1:0] CFG_LAYER_OPACITY = 2'd1;

    // Lanes 0..2 divide for the normal composite, lanes 3..5 for the multiply one.
    typedef struct packed {
        logic [31:0]                 bd;
        logic [31:0]                 sr;
        logic [1:0]                  mode;
        logic [7:0]                  op;
        logic [23:0]                 mc;
        logic [7:0]                  sa;
        logic [8:0]                  ra;
        logic [7:0]                  comp;
        logic [NumLanes-1:0][15:0]   rem;
        logic [NumLanes-1:0][7:0]    quo;
        logic [NumLanes-1:0]         neg;
        logic [31:0]                 nrm;
        logic [31:0]                 mlt;
        logic [31:0]                 first;
        logic [31:0]                 res;
    } t_stage;

    // Rounded product a*b/255 with flooring shifts; a may be a negative difference.
    function automatic logic signed [11:0] mul8(input logic signed [9:0] a,
                                                input logic [7:0] b);
        logic signed [19:0] t;
        logic signed [20:0] u;
        t = 20'(a) * 20'($signed({1'b0, b})) + 20'sd128;
        u = 21'(t >>> 8) + 21'(t);
        return 12'(u >>> 8);
    endfunction

    function automatic logic signed [9:0] diff8(input logic [7:0] x, input logic [7:0] y);
        return $signed({2'b00, x}) - $signed({2'b00, y});
    endfunction

    // Linear merge of s over b at weight w.
    function automatic logic [31:0] merge_px(input logic [31:0] b, input logic [31:0] s,
                                             input logic [7:0] w);
        logic [7:0]         ba;
        logic [7:0]         sa;
        logic [7:0]         bc;
        logic [7:0]         sc;
        logic signed [11:0] m;
        logic signed [11:0] ra;
        logic [23:0]        c;
        ba = b[31:24];
        sa = s[31:24];
        c  = '0;
        for (int k = 0; k < 3; k++) begin
            bc = b[8*k +: 8];
            sc = s[8*k +: 8];
            m  = mul8(diff8(sc, bc), w);
            if (ba == 8'd0) begin
                c[8*k +: 8] = sc;
            end else if (sa == 8'd0) begin
                c[8*k +: 8] = bc;
            end else begin
                c[8*k +: 8] = bc + m[7:0];
            end
        end
        ra = $signed({4'b0000, ba}) + mul8(diff8(sa, ba), w);
        if (ra == 12'sd0) begin
            c = '0;
        end
        return {ra[7:0], c};
    endfunction

endpackage

/* rtl/core/rgba_blend_mode_compositor.sv */
// RGBA blend-mode compositor top level: a fourteen-stage pipeline.
// Depends on rbmc_pkg for the payload type, mode codes and blend arithmetic.
//
// Takes one backdrop/source pixel pair and returns one blended pixel at a sustained
// rate of one pixel per clock while i_stall is low. The pipeline length is set by
// the color division, which resolves one quotient bit per stage in eight stages
// for six channel lanes at once. Each stage holds its item until the
// next one frees up, so bubbles are squeezed out and a stalled output does not stop
// the input until every stage is full. Write the mode and opacity registers only
// while no pixel is in flight.
module rgba_blend_mode_compositor
    import rbmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_backdrop_pixel,
    input  logic [31:0] i_source_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_pixel
);

    logic [1:0]              r_blend_mode;
    logic [7:0]              r_layer_opacity;
    t_stage                  r_pipe [NumStages];
    t_stage                  n_pipe [NumStages];
    logic [NumStages-1:0]    r_valid;
    logic [NumStages:0]      w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode    <= MODE_NORMAL;
            r_layer_opacity <= 8'd255;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BLEND_MODE) begin
                r_blend_mode <= i_cfg_data[1:0];
            end else if (i_cfg_idx == CFG_LAYER_OPACITY) begin
                r_layer_opacity <= i_cfg_data;
            end
        end
    end

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb begin
        w_en[NumStages] = !i_stall;
        for (int k = NumStages - 1; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_stall        = !w_en[0];
    assign o_valid        = r_valid[NumStages-1];
    assign o_result_pixel = r_pipe[NumStages-1].res;

    always_comb begin
        logic signed [11:0] m;
        logic signed [11:0] ra;
        logic signed [9:0]  d;
        logic signed [17:0] num;
        logic [16:0]        dv;
        logic [7:0]         bc;
        logic [7:0]         sc;
        logic [7:0]         qa;
        logic [23:0]        sclr;
        logic [23:0]        c;
        logic [31:0]        px;
        int                 bitn;

        // Input registers.
        n_pipe[0]      = '0;
        n_pipe[0].bd   = i_backdrop_pixel;
        n_pipe[0].sr   = i_source_pixel;
        n_pipe[0].mode = r_blend_mode;
        n_pipe[0].op   = r_layer_opacity;

        // Multiply colors and source alpha at opacity.
        n_pipe[1] = r_pipe[0];
        for (int k = 0; k < 3; k++) begin
            m = mul8($signed({2'b00, r_pipe[0].bd[8*k +: 8]}), r_pipe[0].sr[8*k +: 8]);
            n_pipe[1].mc[8*k +: 8] = m[7:0];
        end
        m = mul8($signed({2'b00, r_pipe[0].sr[31:24]}), r_pipe[0].op);
        n_pipe[1].sa = m[7:0];

        // Result alpha and the signed numerators of the color division.
        n_pipe[2] = r_pipe[1];
        m  = mul8($signed({2'b00, r_pipe[1].bd[31:24]}), r_pipe[1].sa);
        ra = $signed({4'b0000, r_pipe[1].sa}) + $signed({4'b0000, r_pipe[1].bd[31:24]}) - m;
        n_pipe[2].ra   = ra[8:0];
        n_pipe[2].comp = m[7:0];
        for (int l = 0; l < NumLanes; l++) begin
            bc  = r_pipe[1].bd[8*(l%3) +: 8];
            sc  = (l < 3) ? r_pipe[1].sr[8*(l%3) +: 8] : r_pipe[1].mc[8*(l%3) +: 8];
            d   = diff8(sc, bc);
            num = 18'(d) * 18'($signed({1'b0, r_pipe[1].sa}));
            n_pipe[2].neg[l] = num[17];
            n_pipe[2].rem[l] = num[17] ? 16'(-num) : num[15:0];
            n_pipe[2].quo[l] = '0;
        end

        // Restoring division, one quotient bit per stage, most significant first.
        for (int k = DivFirst; k < DivFirst + DivBits; k++) begin
            n_pipe[k] = r_pipe[k-1];
            bitn      = DivFirst + DivBits - 1 - k;
            dv        = 17'(r_pipe[k-1].ra) << bitn;
            for (int l = 0; l < NumLanes; l++) begin
                if ({1'b0, r_pipe[k-1].rem[l]} >= dv) begin
                    n_pipe[k].rem[l]       = r_pipe[k-1].rem[l] - dv[15:0];
                    n_pipe[k].quo[l][bitn] = 1'b1;
                end
            end
        end

        // Build the normal and multiply composites.
        n_pipe[11] = r_pipe[10];
        for (int ln = 0; ln < 2; ln++) begin
            sclr = (ln == 0) ? r_pipe[10].sr[23:0] : r_pipe[10].mc;
            c    = '0;
            for (int k = 0; k < 3; k++) begin
                bc = r_pipe[10].bd[8*k +: 8];
                qa = r_pipe[10].neg[3*ln+k] ? (~r_pipe[10].quo[3*ln+k] + 8'd1)
                                             : r_pipe[10].quo[3*ln+k];
                c[8*k +: 8] = (r_pipe[10].ra == 9'd0) ? bc : bc + qa;
            end
            if (r_pipe[10].bd[31:24] == 8'd0) begin
                px = {r_pipe[10].sa, sclr};
            end else if (r_pipe[10].sr[31:24] == 8'd0) begin
                px = r_pipe[10].bd;
            end else begin
                px = {r_pipe[10].ra[7:0], c};
            end
            if (ln == 0) begin
                n_pipe[11].nrm = px;
            end else begin
                n_pipe[11].mlt = px;
            end
        end

        // First merge pass; merge mode does its only pass here.
        n_pipe[12] = r_pipe[11];
        if (r_pipe[11].mode == MODE_MERGE) begin
            n_pipe[12].first = merge_px(r_pipe[11].bd, r_pipe[11].sr, r_pipe[11].op);
        end else begin
            n_pipe[12].first = merge_px(r_pipe[11].nrm, r_pipe[11].mlt,
                                        r_pipe[11].bd[31:24]);
        end

        // Second merge pass and final selection.
        n_pipe[13] = r_pipe[12];
        unique case (r_pipe[12].mode)
            MODE_NORMAL: n_pipe[13].res = r_pipe[12].nrm;
            MODE_MULT:   n_pipe[13].res = r_pipe[12].mlt;
            MODE_MULT_CORR: begin
                if (r_pipe[12].bd[31:24] == 8'd0) begin
                    n_pipe[13].res = r_pipe[12].nrm;
                end else begin
                    n_pipe[13].res = merge_px(r_pipe[12].first, r_pipe[12].mlt,
                                              r_pipe[12].comp);
                end
            end
            MODE_MERGE:  n_pipe[13].res = r_pipe[12].first;
            default:     n_pipe[13].res = r_pipe[12].nrm;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NumStages; k++) begin
            if (w_en[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Checks on the finished division.
    logic w_rem_ok;
    always_comb begin
        w_rem_ok = 1'b1;
        for (int l = 0; l < NumLanes; l++) begin
            if ({1'b0, r_pipe[11].rem[l]} >= 17'(r_pipe[11].ra)) begin
                w_rem_ok = 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_ra_covers_backdrop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[11] |-> (r_pipe[11].ra >= {1'b0, r_pipe[11].bd[31:24]}))
        else $error("result alpha below backdrop alpha");
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[11] && r_pipe[11].ra != 9'd0) |-> w_rem_ok)
        else $error("division remainder not below divisor");
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[NumStages-1] |-> !o_stall)
        else $error("input stalled with an empty output stage");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule
